// ===== rtl/srsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsv_pkg
// Shared types and codes for the sorted row span validator.
// ----------------------------------------------------------------------------
package srsv_pkg;

	typedef enum logic [1:0] {
		VERDICT_OK         = 2'd0,
		VERDICT_BAD_ZOOM   = 2'd1,
		VERDICT_BAD_EXTENT = 2'd2,
		VERDICT_BAD_COUNT  = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		CFG_LOWEST_ZOOM    = 2'd0,
		CFG_HIGHEST_ZOOM   = 2'd1,
		CFG_DECLARED_TILES = 2'd2
	} cfg_index_t;

	localparam int unsigned CFG_DATA_W = 32;

	typedef struct packed {
		logic [7:0]  span_zoom;
		logic [31:0] span_row;
		logic [31:0] first_column;
		logic [31:0] final_column;
		logic        last_span;
	} span_t;

	// per-span check outcome handed from the checker to the core
	typedef struct packed {
		logic        ok;
		logic        mark_level;
		verdict_t    err;
		logic [31:0] new_sum;
	} span_chk_t;

endpackage

// ===== rtl/srsv_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsv_ifs
// Valid/ready channels for span words in and verdict words out.
// ----------------------------------------------------------------------------
interface srsv_span_if;
	logic        valid;
	logic        ready;
	logic [7:0]  span_zoom;
	logic [31:0] span_row;
	logic [31:0] first_column;
	logic [31:0] final_column;
	logic        last_span;

	modport source (output valid, span_zoom, span_row, first_column, final_column,
		last_span, input ready);
	modport sink (input valid, span_zoom, span_row, first_column, final_column,
		last_span, output ready);
endinterface

interface srsv_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [31:0] tiles_counted;

	modport source (output valid, verdict, tiles_counted, input ready);
	modport sink (input valid, verdict, tiles_counted, output ready);
endinterface

// ===== rtl/srsv_span_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsv_span_check
// Range, extent, ordering and sum checks for one span against list state.
// ----------------------------------------------------------------------------
module srsv_span_check #(
	parameter int unsigned TOP_ZOOM = 20
) (
	input  srsv_pkg::span_t     span,
	input  logic [7:0]          lowest_zoom,
	input  logic [7:0]          highest_zoom,
	input  logic                at_start,
	input  logic [4:0]          prior_zoom,
	input  logic [31:0]         prior_row,
	input  logic [31:0]         prior_last_column,
	input  logic [31:0]         running_tiles,
	output srsv_pkg::span_chk_t chk
);
	import srsv_pkg::*;

	logic [31:0] world_max;
	logic        range_bad;
	logic        extent_bad;
	logic        order_bad;
	logic        same_zoom;
	logic        same_row;
	logic [32:0] width;
	logic [32:0] sum;

	always_comb begin
		range_bad = (span.span_zoom < lowest_zoom) || (span.span_zoom > highest_zoom) ||
			(span.span_zoom > 8'(TOP_ZOOM));
		world_max = (32'd1 << span.span_zoom[4:0]) - 32'd1;
		extent_bad = (span.span_row > world_max) || (span.first_column > span.final_column) ||
			(span.final_column > world_max);
		same_zoom = (span.span_zoom == {3'd0, prior_zoom});
		same_row = same_zoom && (span.span_row == prior_row);
		// touching spans on one row count as overlap
		order_bad = !at_start && ((span.span_zoom < {3'd0, prior_zoom}) ||
			(same_zoom && (span.span_row < prior_row)) ||
			(same_row && ({1'b0, span.first_column} <= ({1'b0, prior_last_column} + 33'd1))));
		width = {1'b0, span.final_column} - {1'b0, span.first_column} + 33'd1;
		sum = {1'b0, running_tiles} + width;

		chk.mark_level = !(range_bad || extent_bad || order_bad);
		chk.new_sum = sum[31:0];
		if (!chk.mark_level) begin
			chk.err = VERDICT_BAD_EXTENT;
		end else if (sum[32]) begin
			chk.err = VERDICT_BAD_COUNT;
		end else begin
			chk.err = VERDICT_OK;
		end
		chk.ok = (chk.err == VERDICT_OK);
	end

endmodule

// ===== rtl/srsv_verdict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsv_verdict
// Final verdict for a list from the state left after its last span.
// ----------------------------------------------------------------------------
module srsv_verdict #(
	parameter int unsigned TOP_ZOOM = 20
) (
	input  logic [7:0]        lowest_zoom,
	input  logic [7:0]        highest_zoom,
	input  logic [31:0]       declared_tiles,
	input  logic              too_long,
	input  srsv_pkg::verdict_t first_error,
	input  logic [TOP_ZOOM:0] levels_seen,
	input  logic [31:0]       running_tiles,
	output srsv_pkg::verdict_t verdict
);
	import srsv_pkg::*;

	logic [TOP_ZOOM:0] expected;

	always_comb begin
		for (int z = 0; z <= int'(TOP_ZOOM); z++) begin
			expected[z] = (8'(z) >= lowest_zoom) && (8'(z) <= highest_zoom);
		end
	end

	always_comb begin
		if ((lowest_zoom > highest_zoom) || (highest_zoom > 8'(TOP_ZOOM))) begin
			verdict = VERDICT_BAD_ZOOM;
		end else if (too_long) begin
			verdict = VERDICT_BAD_EXTENT;
		end else if (first_error != VERDICT_OK) begin
			verdict = first_error;
		end else if (levels_seen != expected) begin
			verdict = VERDICT_BAD_ZOOM;
		end else if ((declared_tiles == 32'd0) || (running_tiles != declared_tiles)) begin
			verdict = VERDICT_BAD_COUNT;
		end else begin
			verdict = VERDICT_OK;
		end
	end

endmodule

// ===== rtl/sorted_row_span_validator_core.sv =====
`timescale 1ns / 1ps
// Flow: a span word is registered at acceptance and checked in the next
// cycle; a last span's verdict word is then registered onto the result channel.
// Throughput: one span word per cycle; the span register stalls only when a
// last span meets a verdict word that has not yet been taken.
// Reset: arst_n clears list state, the configuration registers and both valids.
// ----------------------------------------------------------------------------
// sorted_row_span_validator_core
// Streams tile row spans, checks order and extent, and gives one verdict per list.
// ----------------------------------------------------------------------------
module sorted_row_span_validator_core #(
	parameter int unsigned TOP_ZOOM   = 20,
	parameter int unsigned SPAN_LIMIT = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  srsv_pkg::cfg_index_t            cfg_index,
	input  logic [srsv_pkg::CFG_DATA_W-1:0] cfg_data,
	srsv_span_if.sink                       span,
	srsv_result_if.source                   result
);
	import srsv_pkg::*;

	localparam int unsigned SPAN_W = $clog2(SPAN_LIMIT + 2);

	logic [7:0]        lowest_zoom_q;
	logic [7:0]        highest_zoom_q;
	logic [31:0]       declared_tiles_q;

	span_t             span_s1;
	logic              valid_s1;

	logic [4:0]        prior_zoom_q;
	logic [31:0]       prior_row_q;
	logic [31:0]       prior_last_column_q;
	logic [31:0]       running_tiles_q;
	logic [TOP_ZOOM:0] levels_seen_q;
	logic [SPAN_W-1:0] spans_seen_q;
	verdict_t          first_error_q;
	logic              at_start_q;

	logic              res_valid_q;
	verdict_t          res_verdict_q;
	logic [31:0]       res_tiles_q;

	span_chk_t         chk;
	logic              res_free;
	logic              advance;
	logic              checking;
	logic [TOP_ZOOM:0] level_bit;
	logic [TOP_ZOOM:0] levels_next;
	logic [SPAN_W-1:0] spans_next;
	verdict_t          first_error_next;
	logic [31:0]       running_next;
	verdict_t          verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_zoom_q    <= '0;
			highest_zoom_q   <= '0;
			declared_tiles_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOWEST_ZOOM:    lowest_zoom_q    <= cfg_data[7:0];
				CFG_HIGHEST_ZOOM:   highest_zoom_q   <= cfg_data[7:0];
				CFG_DECLARED_TILES: declared_tiles_q <= cfg_data[31:0];
				default:            ;
			endcase
		end
	end

	// a verdict word may only enter when the output slot frees up
	assign res_free   = !res_valid_q || result.ready;
	assign advance    = valid_s1 && (!span_s1.last_span || res_free);
	assign span.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (span.ready) begin
			valid_s1 <= span.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (span.valid && span.ready) begin
			span_s1.span_zoom    <= span.span_zoom;
			span_s1.span_row     <= span.span_row;
			span_s1.first_column <= span.first_column;
			span_s1.final_column <= span.final_column;
			span_s1.last_span    <= span.last_span;
		end
	end

	srsv_span_check #(
		.TOP_ZOOM(TOP_ZOOM)
	) u_check (
		.span              (span_s1),
		.lowest_zoom       (lowest_zoom_q),
		.highest_zoom      (highest_zoom_q),
		.at_start          (at_start_q),
		.prior_zoom        (prior_zoom_q),
		.prior_row         (prior_row_q),
		.prior_last_column (prior_last_column_q),
		.running_tiles     (running_tiles_q),
		.chk               (chk)
	);

	// once a list has an error, later spans are only counted
	assign checking = (first_error_q == VERDICT_OK);

	always_comb begin
		for (int z = 0; z <= int'(TOP_ZOOM); z++) begin
			level_bit[z] = chk.mark_level && (span_s1.span_zoom == 8'(z));
		end
		levels_next      = checking ? (levels_seen_q | level_bit) : levels_seen_q;
		first_error_next = checking ? chk.err : first_error_q;
		running_next     = (checking && chk.ok) ? chk.new_sum : running_tiles_q;
		spans_next       = (spans_seen_q <= SPAN_W'(SPAN_LIMIT)) ?
			(spans_seen_q + SPAN_W'(1)) : spans_seen_q;
	end

	srsv_verdict #(
		.TOP_ZOOM(TOP_ZOOM)
	) u_verdict (
		.lowest_zoom    (lowest_zoom_q),
		.highest_zoom   (highest_zoom_q),
		.declared_tiles (declared_tiles_q),
		.too_long       (spans_next > SPAN_W'(SPAN_LIMIT)),
		.first_error    (first_error_next),
		.levels_seen    (levels_next),
		.running_tiles  (running_next),
		.verdict        (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_zoom_q        <= '0;
			prior_row_q         <= '0;
			prior_last_column_q <= '0;
			running_tiles_q     <= '0;
			levels_seen_q       <= '0;
			spans_seen_q        <= '0;
			first_error_q       <= VERDICT_OK;
			at_start_q          <= 1'b1;
		end else if (advance) begin
			if (span_s1.last_span) begin
				// clear for the next list
				prior_zoom_q        <= '0;
				prior_row_q         <= '0;
				prior_last_column_q <= '0;
				running_tiles_q     <= '0;
				levels_seen_q       <= '0;
				spans_seen_q        <= '0;
				first_error_q       <= VERDICT_OK;
				at_start_q          <= 1'b1;
			end else begin
				levels_seen_q   <= levels_next;
				spans_seen_q    <= spans_next;
				first_error_q   <= first_error_next;
				running_tiles_q <= running_next;
				if (checking && chk.ok) begin
					prior_zoom_q        <= span_s1.span_zoom[4:0];
					prior_row_q         <= span_s1.span_row;
					prior_last_column_q <= span_s1.final_column;
					at_start_q          <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && span_s1.last_span) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && span_s1.last_span) begin
			res_verdict_q <= verdict;
			res_tiles_q   <= running_next;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.verdict       = res_verdict_q;
	assign result.tiles_counted = res_tiles_q;

endmodule

// ===== rtl/srsv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsv_checker
// Port-level assertions for the span validator, bound to the top level.
// ----------------------------------------------------------------------------
module srsv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        span_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  result_verdict,
	input logic [31:0] result_tiles
);
	import srsv_pkg::*;

	// reset drops the verdict word by the next edge
	a_reset_clears: assert property (@(posedge clk) !arst_n |=> !result_valid)
		else $error("result valid during reset");

	// hold an untaken verdict word
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result word dropped before it was taken");

	// with the output slot empty nothing may block the span side
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> span_ready)
		else $error("span side stalled with empty output");

	// a passing list always has a nonzero declared count matched by the sum
	a_ok_has_tiles: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_verdict == VERDICT_OK) |-> (result_tiles != 32'd0))
		else $error("ok verdict with zero tiles");

endmodule

bind sorted_row_span_validator_core srsv_checker u_srsv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.span_ready     (span.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_verdict (result.verdict),
	.result_tiles   (result.tiles_counted)
);
